### sv/tdp_pkg.sv
`default_nettype none
package tdp_pkg;

    typedef enum logic [1:0] {
        FMT_565  = 2'd0,
        FMT_1555 = 2'd1,
        FMT_4444 = 2'd2
    } fmt_t;

    localparam int unsigned CHAN_W    = 8;
    localparam int unsigned CARRY_W   = 5;
    localparam int unsigned MASK_W    = 4;
    localparam int unsigned TEXEL_W   = 16;
    localparam int unsigned ADDR_W    = 20;
    localparam int unsigned MODE_W    = 2;
    localparam int unsigned QUEUE_DEPTH = 2;
    localparam int unsigned QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
    localparam int unsigned QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    localparam logic              MODE_REG_IDX = 1'b0;
    localparam logic [CHAN_W-1:0] CHAN_MAX   = 8'hff;
    localparam logic [MASK_W-1:0] MASK_DROP2 = 4'h3;
    localparam logic [MASK_W-1:0] MASK_DROP3 = 4'h7;
    localparam logic [MASK_W-1:0] MASK_DROP4 = 4'hf;
    localparam logic [CHAN_W-1:0] PUNCH_MIN  = 8'd2;

    typedef struct packed {
        logic                start;
        fmt_t                fmt;
        logic [CHAN_W-1:0]   alpha;
        logic [CHAN_W-1:0]   red;
        logic [CHAN_W-1:0]   green;
        logic [CHAN_W-1:0]   blue;
        logic [MASK_W-1:0]   red_mask;
        logic [MASK_W-1:0]   green_mask;
        logic [MASK_W-1:0]   blue_mask;
        logic [ADDR_W-1:0]   addr;
    } word_t;

    function automatic logic [CHAN_W-1:0] dither_sum(
        input logic [CHAN_W-1:0]  chan,
        input logic [CARRY_W-1:0] carry
    );
        logic [CHAN_W:0] sum;
        sum = {1'b0, chan} + {{(CHAN_W+1-CARRY_W){1'b0}}, carry};
        return sum[CHAN_W] ? CHAN_MAX : sum[CHAN_W-1:0];
    endfunction

    function automatic logic [CARRY_W-1:0] carry_update(
        input logic [CARRY_W-1:0] carry,
        input logic [CHAN_W-1:0]  sat,
        input logic [MASK_W-1:0]  mask
    );
        logic [MASK_W-1:0] old_low;
        logic [MASK_W-1:0] new_low;
        old_low = carry[MASK_W-1:0] & mask;
        new_low = sat[MASK_W-1:0] & mask;
        return {1'b0, old_low} + {1'b0, new_low};
    endfunction

    function automatic logic [TEXEL_W-1:0] pack_texel(
        input fmt_t              fmt,
        input logic [CHAN_W-1:0] a,
        input logic [CHAN_W-1:0] r,
        input logic [CHAN_W-1:0] g,
        input logic [CHAN_W-1:0] b
    );
        logic [TEXEL_W-1:0] t;
        unique case (fmt)
            FMT_1555: t = {(a >= PUNCH_MIN), r[7:3], g[7:3], b[7:3]};
            FMT_4444: t = {a[7:4], r[7:4], g[7:4], b[7:4]};
            default:  t = {r[7:3], g[7:2], b[7:3]};
        endcase
        return t;
    endfunction

endpackage
`default_nettype wire

### sv/tdp_front.sv
`default_nettype none
module tdp_front
    import tdp_pkg::*;
#(
    parameter int unsigned COORD_BITS = 10
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic [MODE_W-1:0]     pack_mode,
    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  wire logic                  start_of_image,
    input  wire logic [CHAN_W-1:0]     alpha_in,
    input  wire logic [CHAN_W-1:0]     red_in,
    input  wire logic [CHAN_W-1:0]     green_in,
    input  wire logic [CHAN_W-1:0]     blue_in,
    input  wire logic [COORD_BITS-1:0] column,
    input  wire logic [COORD_BITS-1:0] row,
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output word_t                      out_word
);

    logic  valid_reg;
    logic  valid_next;
    word_t word_reg;
    word_t word_next;
    logic  [ADDR_W-1:0] addr;
    fmt_t  fmt;

    always_comb begin
        addr = '0;
        for (int k = 0; k < COORD_BITS; k++) begin
            addr[2*k]     = row[k];
            addr[2*k + 1] = column[k];
        end
    end

    always_comb begin
        unique case (pack_mode)
            FMT_1555: fmt = FMT_1555;
            FMT_4444: fmt = FMT_4444;
            default:  fmt = FMT_565;
        endcase
    end

    always_comb begin
        word_next.start = start_of_image;
        word_next.fmt   = fmt;
        word_next.alpha = alpha_in;
        word_next.red   = red_in;
        word_next.green = green_in;
        word_next.blue  = blue_in;
        word_next.addr  = addr;
        unique case (fmt)
            FMT_1555: begin
                word_next.red_mask   = MASK_DROP3;
                word_next.green_mask = MASK_DROP3;
                word_next.blue_mask  = MASK_DROP3;
            end
            FMT_4444: begin
                word_next.red_mask   = MASK_DROP4;
                word_next.green_mask = MASK_DROP4;
                word_next.blue_mask  = MASK_DROP4;
            end
            default: begin
                word_next.red_mask   = MASK_DROP3;
                word_next.green_mask = MASK_DROP2;
                word_next.blue_mask  = MASK_DROP3;
            end
        endcase
    end

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_word  = word_reg;

    always_comb begin
        valid_next = valid_reg;
        if (in_ready) begin
            valid_next = in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            word_reg <= word_next;
        end
    end

endmodule
`default_nettype wire

### sv/tdp_queue.sv
`default_nettype none
module tdp_queue
    import tdp_pkg::*;
(
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic in_valid,
    output logic      in_ready,
    input  word_t     in_word,
    output logic      out_valid,
    input  wire logic out_ready,
    output word_t     out_word
);

    word_t                  mem [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] wr_ptr_reg;
    logic [QUEUE_PTR_W-1:0] wr_ptr_next;
    logic [QUEUE_PTR_W-1:0] rd_ptr_reg;
    logic [QUEUE_PTR_W-1:0] rd_ptr_next;
    logic [QUEUE_CNT_W-1:0] count_reg;
    logic [QUEUE_CNT_W-1:0] count_next;
    logic                   push;
    logic                   pop;

    localparam logic [QUEUE_CNT_W-1:0] FULL_CNT = QUEUE_CNT_W'(QUEUE_DEPTH);
    localparam logic [QUEUE_PTR_W-1:0] LAST_PTR = QUEUE_PTR_W'(QUEUE_DEPTH - 1);

    assign in_ready  = (count_reg != FULL_CNT);
    assign out_valid = (count_reg != '0);
    assign out_word  = mem[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= in_word;
        end
    end

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= FULL_CNT)
        else $error("queue count above depth");

    a_count_up: assert property (@(posedge aclk) disable iff (!aresetn)
        (push && !pop) |=> count_reg == $past(count_reg) + 1'b1)
        else $error("queue count did not advance on push");

    a_count_down: assert property (@(posedge aclk) disable iff (!aresetn)
        (pop && !push) |=> count_reg == $past(count_reg) - 1'b1)
        else $error("queue count did not drop on pop");

    a_ptr_gap: assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg == '0) |-> (wr_ptr_reg == rd_ptr_reg))
        else $error("empty queue with pointers apart");

endmodule
`default_nettype wire

### sv/tdp_back.sv
`default_nettype none
module tdp_back
    import tdp_pkg::*;
(
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  word_t                   in_word,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic [TEXEL_W-1:0]      out_texel,
    output logic [ADDR_W-1:0]       out_addr
);

    logic [CARRY_W-1:0]  r_carry_reg;
    logic [CARRY_W-1:0]  r_carry_next;
    logic [CARRY_W-1:0]  g_carry_reg;
    logic [CARRY_W-1:0]  g_carry_next;
    logic [CARRY_W-1:0]  b_carry_reg;
    logic [CARRY_W-1:0]  b_carry_next;
    logic [CARRY_W-1:0]  r_carry;
    logic [CARRY_W-1:0]  g_carry;
    logic [CARRY_W-1:0]  b_carry;
    logic [CHAN_W-1:0]   r_sat;
    logic [CHAN_W-1:0]   g_sat;
    logic [CHAN_W-1:0]   b_sat;
    logic                valid_reg;
    logic                valid_next;
    logic [TEXEL_W-1:0]  texel_reg;
    logic [TEXEL_W-1:0]  texel_next;
    logic [ADDR_W-1:0]   addr_reg;
    logic                fire;

    assign in_ready = !valid_reg || out_ready;
    assign fire     = in_valid && in_ready;

    always_comb begin
        r_carry = in_word.start ? '0 : r_carry_reg;
        g_carry = in_word.start ? '0 : g_carry_reg;
        b_carry = in_word.start ? '0 : b_carry_reg;
        r_sat   = dither_sum(in_word.red, r_carry);
        g_sat   = dither_sum(in_word.green, g_carry);
        b_sat   = dither_sum(in_word.blue, b_carry);
        r_carry_next = carry_update(r_carry, r_sat, in_word.red_mask);
        g_carry_next = carry_update(g_carry, g_sat, in_word.green_mask);
        b_carry_next = carry_update(b_carry, b_sat, in_word.blue_mask);
        texel_next   = pack_texel(in_word.fmt, in_word.alpha, r_sat, g_sat, b_sat);
    end

    always_comb begin
        valid_next = valid_reg;
        if (in_ready) begin
            valid_next = in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg     <= 1'b0;
            r_carry_reg   <= '0;
            g_carry_reg   <= '0;
            b_carry_reg   <= '0;
        end else begin
            valid_reg     <= valid_next;
            if (fire) begin
                r_carry_reg <= r_carry_next;
                g_carry_reg <= g_carry_next;
                b_carry_reg <= b_carry_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            texel_reg <= texel_next;
            addr_reg  <= in_word.addr;
        end
    end

    assign out_valid = valid_reg;
    assign out_texel = texel_reg;
    assign out_addr  = addr_reg;

    a_hold_stalled: assert property (@(posedge aclk) disable iff (!aresetn)
        (valid_reg && !out_ready) |=> valid_reg && $stable(texel_reg) && $stable(addr_reg))
        else $error("result changed while stalled");

    a_carry_still: assert property (@(posedge aclk) disable iff (!aresetn)
        !fire |=> $stable(r_carry_reg) && $stable(g_carry_reg) && $stable(b_carry_reg))
        else $error("carry moved without a word");

    a_carry_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (r_carry_reg <= 5'd30) && (g_carry_reg <= 5'd30) && (b_carry_reg <= 5'd30))
        else $error("carry out of range");

endmodule
`default_nettype wire

### sv/twiddled_texel_dither_pack_core.sv
// A word goes via front register, two-entry queue and output register to m_valid.
// Throughput: one word per cycle while m_ready stays high.
// The back stage's carry add, saturate and mask are combinational before its register.
// Reset: aresetn synchronous, active low; clears valids, queue, carries, pack_mode.
// No clearing pass after reset; the block takes words on the first cycle out of reset.
`default_nettype none
module twiddled_texel_dither_pack_core
    import tdp_pkg::*;
#(
    parameter int unsigned COORD_BITS = 10
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [2:0]            paddr,
    input  wire logic [31:0]           pwdata,
    output logic      [31:0]           prdata,
    output logic                       pready,
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire logic                  s_start_of_image,
    input  wire logic [CHAN_W-1:0]     s_alpha_in,
    input  wire logic [CHAN_W-1:0]     s_red_in,
    input  wire logic [CHAN_W-1:0]     s_green_in,
    input  wire logic [CHAN_W-1:0]     s_blue_in,
    input  wire logic [COORD_BITS-1:0] s_column,
    input  wire logic [COORD_BITS-1:0] s_row,
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output logic [TEXEL_W-1:0]         m_texel,
    output logic [ADDR_W-1:0]          m_twiddle_address
);

    logic [MODE_W-1:0] pack_mode_reg;
    logic [MODE_W-1:0] pack_mode_next;
    logic              cfg_write;
    logic              front_valid;
    logic              front_ready;
    word_t             front_word;
    logic              queue_valid;
    logic              queue_ready;
    word_t             queue_word;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign prdata    = (paddr[2] == MODE_REG_IDX) ? {{(32-MODE_W){1'b0}}, pack_mode_reg} : '0;

    always_comb begin
        pack_mode_next = pack_mode_reg;
        if (cfg_write && (paddr[2] == MODE_REG_IDX)) begin
            pack_mode_next = pwdata[MODE_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pack_mode_reg <= '0;
        end else begin
            pack_mode_reg <= pack_mode_next;
        end
    end

    tdp_front #(
        .COORD_BITS(COORD_BITS)
    ) u_front (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .pack_mode      (pack_mode_reg),
        .in_valid       (s_valid),
        .in_ready       (s_ready),
        .start_of_image (s_start_of_image),
        .alpha_in       (s_alpha_in),
        .red_in         (s_red_in),
        .green_in       (s_green_in),
        .blue_in        (s_blue_in),
        .column         (s_column),
        .row            (s_row),
        .out_valid      (front_valid),
        .out_ready      (front_ready),
        .out_word       (front_word)
    );

    tdp_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (front_valid),
        .in_ready  (front_ready),
        .in_word   (front_word),
        .out_valid (queue_valid),
        .out_ready (queue_ready),
        .out_word  (queue_word)
    );

    tdp_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (queue_valid),
        .in_ready  (queue_ready),
        .in_word   (queue_word),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_texel (m_texel),
        .out_addr  (m_twiddle_address)
    );

endmodule
`default_nettype wire
